FILE: hdl/assert_macros.svh
// Assertion macros used by the edge filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cnef_pkg.sv
// Shared constants and types of the cross-neighbour edge filter.
package cnef_pkg;

  localparam int unsigned WIDTH_REG_W  = 13;
  localparam int unsigned HEIGHT_REG_W = 16;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned EDGE_W       = 16;
  localparam int unsigned OUT_COL_W    = 12;
  localparam int unsigned ROW_W        = 16;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_LVL_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIGNED = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd4096;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd4096;

  typedef struct packed {
    logic [EDGE_W-1:0]    edge_value;
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 has_up;
    logic                 last_row;
    logic                 last_col;
  } cnef_rec_t;

endpackage

FILE: hdl/cnef_if.sv
// Valid/ready stream interfaces for pixel requests and edge results.
interface cnef_pix_if #(
  parameter int PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface cnef_res_if;
  import cnef_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [EDGE_W-1:0]    edge_value;
  logic [OUT_COL_W-1:0] out_col;
  logic [ROW_W-1:0]     out_row;
  logic                 last_in_run;
  logic                 end_of_frame;

  modport source (output valid, output edge_value, output out_col, output out_row,
                  output last_in_run, output end_of_frame, input ready);
  modport sink (input valid, input edge_value, input out_col, input out_row,
                input last_in_run, input end_of_frame, output ready);
endinterface

FILE: hdl/cross_neighbour_edge_filter.sv
// Top level of the cross-neighbour edge filter.
//
// Pixels of one plane enter in raster order on pix_i, one request per
// accepted valid/ready beat. Edge results leave on res_o with their column
// and row. A pixel on row r gives the result of pixel (r-1, c) once r >= 1,
// and on the last row also the zero of its own border pixel; row 0 gives
// nothing unless it is the last row. Interior results are the largest
// absolute difference to the four cross neighbours; border results are 0.
// Configuration (width, height, signed mode) is written on the cfg port.
// Each result passes stage 1, stage 2 and the result queue.
// Throughput: one pixel per cycle while the result queue has room, set by
// the single upper-row write and two reads per pixel; on the last row each
// pixel's two results leave as separate output beats, which slows intake.
// Reset clears the counters, the pipeline and the result queue and loads
// width 4096, height 4096, unsigned mode. Line stores are not cleared.
// When res_o stalls, up to four pixels' results are held in flight; pix_i
// drops ready once that room is taken and resumes as results drain.
`include "assert_macros.svh"
module cross_neighbour_edge_filter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cnef_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cnef_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  cnef_pix_if.sink                         pix_i,
  cnef_res_if.source                       res_o
);
  import cnef_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned OCC_W = QUEUE_LVL_W + 1;
  localparam logic [PIXEL_BITS-1:0] SIGN_BIT   = {1'b1, {(PIXEL_BITS-1){1'b0}}};
  localparam logic [PIXEL_BITS-1:0] SIGNED_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};

  function automatic logic [PIXEL_BITS-1:0] abs_diff(input logic [PIXEL_BITS-1:0] a,
                                                     input logic [PIXEL_BITS-1:0] b,
                                                     input logic sgn);
    logic [PIXEL_BITS-1:0] ua;
    logic [PIXEL_BITS-1:0] ub;
    ua = sgn ? (a ^ SIGN_BIT) : a;
    ub = sgn ? (b ^ SIGN_BIT) : b;
    return (ua > ub) ? (ua - ub) : (ub - ua);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic                    signed_q;

  logic [COL_W-1:0]        last_col_idx;
  logic [ROW_W-1:0]        last_row_idx;
  logic [COL_W-1:0]        col_q;
  logic [ROW_W-1:0]        row_q;
  logic                    accept;
  logic                    at_last_col;
  logic                    at_last_row;
  logic                    interior;
  logic                    fwd_now;
  logic [COL_W-1:0]        right_addr;

  logic                    s1_valid_q;
  logic [PIXEL_BITS-1:0]   s1_pix_q;
  logic [COL_W-1:0]        s1_col_q;
  logic [ROW_W-1:0]        s1_row_q;
  logic                    s1_has_up_q;
  logic                    s1_last_row_q;
  logic                    s1_last_col_q;
  logic                    s1_interior_q;
  logic                    s1_fwd_q;

  logic [PIXEL_BITS-1:0]   centre_rd;
  logic [PIXEL_BITS-1:0]   right_rd;
  logic [PIXEL_BITS-1:0]   above_rd;
  logic [PIXEL_BITS-1:0]   above;
  logic [PIXEL_BITS-1:0]   last_centre_q;

  logic                    s2_valid_q;
  logic [PIXEL_BITS-1:0]   s2_dup_q;
  logic [PIXEL_BITS-1:0]   s2_ddn_q;
  logic [PIXEL_BITS-1:0]   s2_dlf_q;
  logic [PIXEL_BITS-1:0]   s2_drt_q;
  logic [COL_W-1:0]        s2_col_q;
  logic [ROW_W-1:0]        s2_row_q;
  logic                    s2_has_up_q;
  logic                    s2_last_row_q;
  logic                    s2_last_col_q;
  logic                    s2_interior_q;

  logic [PIXEL_BITS-1:0]   edge_max;
  logic [PIXEL_BITS-1:0]   edge_sat;
  logic                    push;
  cnef_rec_t               rec;
  logic [QUEUE_LVL_W-1:0]  level;
  logic [OCC_W-1:0]        occupancy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      signed_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        REG_PIXEL_SIGNED: signed_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      last_col_idx = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      last_col_idx = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_idx = COL_W'(32'(width_q) - 32'd1);
    end
  end

  assign last_row_idx = (height_q == '0) ? '0 : (height_q - HEIGHT_REG_W'(1));

  // position and request acceptance
  assign occupancy = {1'b0, level} + OCC_W'(s1_valid_q) + OCC_W'(s2_valid_q);
  assign pix_i.ready = (occupancy < OCC_W'(QUEUE_DEPTH));
  assign accept      = pix_i.valid && pix_i.ready;

  assign at_last_col = (col_q >= last_col_idx);
  assign at_last_row = (row_q >= last_row_idx);
  assign interior    = (row_q >= ROW_W'(2)) && ((row_q - ROW_W'(1)) < last_row_idx) &&
                       (col_q != '0) && (col_q < last_col_idx);
  assign right_addr  = (col_q == COL_W'(MAX_WIDTH - 1)) ? col_q : (col_q + COL_W'(1));
  assign fwd_now     = s1_valid_q && s1_has_up_q && (s1_col_q == col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_q <= '0;
        row_q <= at_last_row ? '0 : (row_q + ROW_W'(1));
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  cnef_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_store (
    .clk_i         (clk_i),
    .acc_i         (accept),
    .centre_addr_i (col_q),
    .right_addr_i  (right_addr),
    .pix_i         (pix_i.pixel_value),
    .old_we_i      (s1_valid_q && s1_has_up_q),
    .old_waddr_i   (s1_col_q),
    .old_wdata_i   (centre_rd),
    .centre_o      (centre_rd),
    .right_o       (right_rd),
    .above_o       (above_rd)
  );

  // stage 1: line store data back, absolute differences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q      <= pix_i.pixel_value;
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_has_up_q   <= (row_q != '0);
      s1_last_row_q <= at_last_row;
      s1_last_col_q <= at_last_col;
      s1_interior_q <= interior;
      s1_fwd_q      <= fwd_now;
    end
  end

  // forward the row-before-last entry written in the same cycle it is read
  assign above = s1_fwd_q ? last_centre_q : above_rd;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      last_centre_q <= centre_rd;
      s2_dup_q      <= abs_diff(centre_rd, above, signed_q);
      s2_ddn_q      <= abs_diff(centre_rd, s1_pix_q, signed_q);
      s2_dlf_q      <= abs_diff(centre_rd, last_centre_q, signed_q);
      s2_drt_q      <= abs_diff(centre_rd, right_rd, signed_q);
      s2_col_q      <= s1_col_q;
      s2_row_q      <= s1_row_q;
      s2_has_up_q   <= s1_has_up_q;
      s2_last_row_q <= s1_last_row_q;
      s2_last_col_q <= s1_last_col_q;
      s2_interior_q <= s1_interior_q;
    end
  end

  // stage 2: maximum, saturation, result record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  assign edge_max = max2(max2(s2_dup_q, s2_ddn_q), max2(s2_dlf_q, s2_drt_q));
  assign edge_sat = (signed_q && edge_max[PIXEL_BITS-1]) ? SIGNED_MAX : edge_max;

  assign push          = s2_valid_q && (s2_has_up_q || s2_last_row_q);
  assign rec.edge_value = s2_interior_q ? EDGE_W'(edge_sat) : '0;
  assign rec.col       = OUT_COL_W'(s2_col_q);
  assign rec.row       = s2_row_q;
  assign rec.has_up    = s2_has_up_q;
  assign rec.last_row  = s2_last_row_q;
  assign rec.last_col  = s2_last_col_q;

  cnef_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .level_o (level),
    .res_o   (res_o)
  );

  `ASSERT_IMPLIES(a_queue_room, clk_i, rst_ni, 1'b1, occupancy <= OCC_W'(QUEUE_DEPTH), "result queue overrun")
  `ASSERT_NEXT(a_s1_load, clk_i, rst_ni, accept, s1_valid_q, "accepted pixel missing in stage 1")
  `ASSERT_NEXT(a_frame_wrap, clk_i, rst_ni, accept && at_last_col && at_last_row, (col_q == '0) && (row_q == '0), "position did not wrap at end of plane")

endmodule

FILE: hdl/cnef_line_store.sv
// Two line stores: previous row (two read ports) and the row before it.
module cnef_line_store #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  acc_i,
  input  logic [AW-1:0]         centre_addr_i,
  input  logic [AW-1:0]         right_addr_i,
  input  logic [PIXEL_BITS-1:0] pix_i,
  input  logic                  old_we_i,
  input  logic [AW-1:0]         old_waddr_i,
  input  logic [PIXEL_BITS-1:0] old_wdata_i,
  output logic [PIXEL_BITS-1:0] centre_o,
  output logic [PIXEL_BITS-1:0] right_o,
  output logic [PIXEL_BITS-1:0] above_o
);

  logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] centre_q;
  logic [PIXEL_BITS-1:0] right_q;
  logic [PIXEL_BITS-1:0] above_q;

  // read-first: a read at the written address returns the old row
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      upper_mem[centre_addr_i] <= pix_i;
      centre_q                 <= upper_mem[centre_addr_i];
      right_q                  <= upper_mem[right_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (old_we_i) begin
      older_mem[old_waddr_i] <= old_wdata_i;
    end
    if (acc_i) begin
      above_q <= older_mem[centre_addr_i];
    end
  end

  assign centre_o = centre_q;
  assign right_o  = right_q;
  assign above_o  = above_q;

endmodule

FILE: hdl/cnef_res_queue.sv
// Result record queue and output beat sequencer.
module cnef_res_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  cnef_pkg::cnef_rec_t               rec_i,
  output logic [cnef_pkg::QUEUE_LVL_W-1:0]  level_o,
  cnef_res_if.source                        res_o
);
  import cnef_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  cnef_rec_t                store_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_q;
  logic [PTR_W-1:0]         rd_ptr_q;
  logic [QUEUE_LVL_W-1:0]   level_q;
  logic                     beat_q;
  cnef_rec_t                head;
  logic                     two_beats;
  logic                     emit_up;
  logic                     take;
  logic                     pop;

  assign head      = store_q[rd_ptr_q];
  assign two_beats = head.has_up && head.last_row;
  assign emit_up   = head.has_up && !beat_q;
  assign take      = res_o.valid && res_o.ready;
  assign pop       = take && (beat_q || !two_beats);

  assign res_o.valid        = (level_q != '0);
  assign res_o.edge_value   = emit_up ? head.edge_value : '0;
  assign res_o.out_col      = head.col;
  assign res_o.out_row      = emit_up ? (head.row - ROW_W'(1)) : head.row;
  assign res_o.last_in_run  = emit_up ? !head.last_row : 1'b1;
  assign res_o.end_of_frame = emit_up ? 1'b0 : head.last_col;
  assign level_o            = level_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
      beat_q   <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      level_q <= level_q + QUEUE_LVL_W'(push_i) - QUEUE_LVL_W'(pop);
      if (take) begin
        beat_q <= two_beats && !beat_q;
      end
    end
  end

endmodule
